### rtl/lbe_pkg.sv
// shared constants and types for the lagrange basis evaluator
// no dependencies
package lbe_pkg;

  localparam int NodesMaxDef = 16;
  localparam int IdxW        = 4;
  localparam int CntW        = 5;
  localparam int DataW       = 32;

  localparam logic [DataW-1:0] OneQ16  = 32'h0001_0000;
  localparam logic [DataW-1:0] PosLim  = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] NegLim  = 32'h8000_0000;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusSat  = 2'd1;
  localparam logic [1:0] StatusDivZ = 2'd2;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_CALC,
    ST_EMIT
  } state_e;

endpackage

### rtl/lbe_node_cell.sv
// one node cell of the rotating node ring
// depends on lbe_pkg
module lbe_node_cell (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [lbe_pkg::DataW-1:0] load_val_i,
  input  logic                      shift_i,
  input  logic [lbe_pkg::DataW-1:0] next_i,
  output logic [lbe_pkg::DataW-1:0] node_o
);
  import lbe_pkg::*;

  logic [DataW-1:0] node_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      node_q <= load_val_i;
    end else if (shift_i) begin
      node_q <= next_i;
    end
  end

  assign node_o = node_q;
endmodule

### rtl/lbe_muldiv.sv
// multiply then restoring divide, one quotient bit per cycle
// depends on lbe_pkg
module lbe_muldiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lbe_pkg::DataW-1:0] mag_i,
  input  logic [lbe_pkg::DataW:0]   nmag_i,
  input  logic [lbe_pkg::DataW:0]   dmag_i,
  output logic                      done_o,
  output logic [63:0]               quo_o
);
  import lbe_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [63:0]       quo_q;
  logic [DataW:0]    rem_q;
  logic [DataW:0]    dmag_q;
  logic [DataW+1:0]  rem_sh;
  logic [DataW+1:0]  diff;
  logic [64:0]       prod;

  assign prod   = 65'(mag_i) * 65'(nmag_i);
  assign rem_sh = {rem_q, quo_q[63]};
  assign diff   = rem_sh - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= prod[63:0];
      rem_q  <= '0;
      dmag_q <= dmag_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in 33 bits
      if (!diff[DataW+1]) begin
        rem_q <= diff[DataW:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataW:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### rtl/lagrange_basis_evaluator.sv
// lagrange basis evaluator top level: node ring, sequencer, output register
// depends on lbe_pkg, lbe_node_cell, lbe_muldiv
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, mode/index/value/point | item in
//  out     | out_valid_o, out_stall_i, basis fields    | item out
//  cfg     | cfg_valid_i, cfg_ready_o, node_count_i    | register write
//
// an evaluate item runs, for each basis, a scan pass over the ring and then a
// walk pass in which each factor starts the 64-step divider and waits for its
// quotient, so the ring rotates fully twice per basis
// a load item is written into its node cell when accepted; nothing after reset needs a clearing pass
// the output register lets a basis value wait under stall while the next
// one is worked out; the sequencer only holds when a second value is ready
module lagrange_basis_evaluator #(
  parameter int NODES_MAX = lbe_pkg::NodesMaxDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lbe_pkg::CntW-1:0]  node_count_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [lbe_pkg::IdxW-1:0]  node_index_i,
  input  logic signed [lbe_pkg::DataW-1:0] node_value_i,
  input  logic signed [lbe_pkg::DataW-1:0] point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lbe_pkg::IdxW-1:0]  basis_index_o,
  output logic signed [lbe_pkg::DataW-1:0] basis_value_o,
  output logic                      last_o,
  output logic [1:0]                status_o
);
  import lbe_pkg::*;

  localparam int KW  = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;
  localparam int Lim = (NODES_MAX < 16) ? NODES_MAX : 16;
  localparam logic [KW-1:0]   KLast = KW'(NODES_MAX - 1);
  localparam logic [CntW-1:0] LimC  = CntW'(Lim);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   n_q, n_d;
  logic [KW-1:0]     k_q, k_d;
  logic [IdxW-1:0]   i_q, i_d;
  logic [DataW-1:0]  x_q, x_d;
  logic [DataW-1:0]  xi_q, xi_d;
  logic [DataW-1:0]  mag_q, mag_d;
  logic              neg_q, neg_d, sat_q, sat_d, dz_q, dz_d;
  logic              nneg_q, nneg_d, dneg_q, dneg_d;
  logic              ov_q, ov_d;
  logic [IdxW-1:0]   oidx_q, oidx_d;
  logic [DataW-1:0]  oval_q, oval_d;
  logic              olast_q, olast_d;
  logic [1:0]        ostat_q, ostat_d;

  logic              shift;
  logic              md_start;
  logic              md_done;
  logic [63:0]       md_quo;
  logic [DataW-1:0]  ring [NODES_MAX];
  logic [DataW-1:0]  head;
  logic [DataW:0]    num, den, nmag, dmag;
  logic [CntW-1:0]   n_eff;
  logic [7:0]        k8, i8, n8;
  logic              in_acc, out_free;
  logic              q_neg;
  logic [DataW-1:0]  q_lim;
  logic              q_sat;

  // ring of node cells, cell 0 is the head
  for (genvar g = 0; g < NODES_MAX; g++) begin : g_cell
    logic ld;
    assign ld = in_acc && (mode_i == ModeLoad) && ({4'b0, node_index_i} == 8'(g));
    lbe_node_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ld),
      .load_val_i (node_value_i),
      .shift_i    (shift),
      .next_i     (ring[(g + 1) % NODES_MAX]),
      .node_o     (ring[g])
    );
  end

  assign head = ring[0];
  assign num  = {x_q[DataW-1], x_q} - {head[DataW-1], head};
  assign den  = {xi_q[DataW-1], xi_q} - {head[DataW-1], head};
  assign nmag = num[DataW] ? (DataW+1)'(-num) : num;
  assign dmag = den[DataW] ? (DataW+1)'(-den) : den;

  lbe_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_i   (mag_q),
    .nmag_i  (nmag),
    .dmag_i  (dmag),
    .done_o  (md_done),
    .quo_o   (md_quo)
  );

  assign n_eff = (cnt_q == '0) ? CntW'(1) : ((cnt_q > LimC) ? LimC : cnt_q);
  assign k8 = 8'(k_q);
  assign i8 = {4'b0, i_q};
  assign n8 = {3'b0, n_q};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || !out_stall_i;

  // sign and saturation of a finished quotient
  assign q_neg = (md_quo != 64'd0) && (neg_q ^ nneg_q ^ dneg_q);
  assign q_lim = q_neg ? NegLim : PosLim;
  assign q_sat = md_quo > {32'b0, q_lim};

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    i_d      = i_q;
    x_d      = x_q;
    xi_d     = xi_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    sat_d    = sat_q;
    dz_d     = dz_q;
    nneg_d   = nneg_q;
    dneg_d   = dneg_q;
    ov_d     = ov_q && out_stall_i;
    oidx_d   = oidx_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;
    shift    = 1'b0;
    md_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == ModeEval)) begin
          x_d     = point_i;
          n_d     = n_eff;
          i_d     = '0;
          k_d     = '0;
          mag_d   = OneQ16;
          neg_d   = 1'b0;
          sat_d   = 1'b0;
          dz_d    = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k8 == i8) begin
          xi_d = head;
        end
        shift = 1'b1;
        if (k_q == KLast) begin
          k_d     = '0;
          state_d = ST_WALK;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_WALK: begin
        if ((k8 < n8) && (k8 != i8) && !dz_q && (den != '0)) begin
          md_start = 1'b1;
          nneg_d   = num[DataW];
          dneg_d   = den[DataW];
          state_d  = ST_CALC;
        end else begin
          if ((k8 < n8) && (k8 != i8) && (den == '0)) begin
            dz_d = 1'b1;
          end
          shift = 1'b1;
          if (k_q == KLast) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      ST_CALC: begin
        if (md_done) begin
          neg_d = q_neg;
          if (q_sat) begin
            mag_d = q_lim;
            sat_d = 1'b1;
          end else begin
            mag_d = md_quo[DataW-1:0];
          end
          shift = 1'b1;
          if (k_q == KLast) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_WALK;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oidx_d  = i_q;
          olast_d = (i8 + 8'd1) == n8;
          if (dz_q) begin
            oval_d  = '0;
            ostat_d = StatusDivZ;
          end else begin
            oval_d  = neg_q ? DataW'(-mag_q) : mag_q;
            ostat_d = sat_q ? StatusSat : StatusOk;
          end
          if ((i8 + 8'd1) == n8) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + IdxW'(1);
            mag_d   = OneQ16;
            neg_d   = 1'b0;
            sat_d   = 1'b0;
            dz_d    = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= CntW'(1);
      k_q     <= '0;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_q <= node_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    x_q     <= x_d;
    xi_q    <= xi_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    dz_q    <= dz_d;
    nneg_q  <= nneg_d;
    dneg_q  <= dneg_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o   = ov_q;
  assign basis_index_o = oidx_q;
  assign basis_value_o = oval_q;
  assign last_o        = olast_q;
  assign status_o      = ostat_q;
endmodule

### sim/tb_top.sv
// self-checking testbench for the lagrange basis evaluator
// depends on lbe_pkg and lagrange_basis_evaluator; predicts basis values in q16.16
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbe_pkg::*;

  typedef struct {
    logic                    mode;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] point;
  } node_item_t;

  typedef struct {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] value;
    logic                    last;
    logic [1:0]              status;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CntW-1:0] node_count_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = ModeLoad;
  logic [IdxW-1:0] node_index_i = '0;
  logic signed [DataW-1:0] node_value_i = '0;
  logic signed [DataW-1:0] point_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IdxW-1:0] basis_index_o;
  logic signed [DataW-1:0] basis_value_o;
  logic last_o;
  logic [1:0] status_o;

  lagrange_basis_evaluator DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .node_count_i,
    .in_valid_i, .in_stall_o, .mode_i, .node_index_i, .node_value_i, .point_i,
    .out_valid_o, .out_stall_i, .basis_index_o, .basis_value_o, .last_o, .status_o
  );

  always #6 clk_i = ~clk_i;

  node_item_t pending_q[$];
  basis_t     basis_q[$];
  logic [DataW-1:0] node_mem[16];
  logic [CntW-1:0]  count_reg = 5'd1;
  int err_cnt = 0;
  int sent_cnt = 0;
  int acc_cnt = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  bit calm = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // fill the expected queue with one evaluation at point x
  task automatic predict_basis(input logic signed [DataW-1:0] x);
    int n;
    longint signed xi, xj, num, den;
    longint unsigned mag, q, lim;
    bit neg, sat, dz;
    basis_t b;
    n = (count_reg == 0) ? 1 : (count_reg > 16 ? 16 : int'(count_reg));
    for (int i = 0; i < n; i++) begin
      mag = OneQ16; neg = 0; sat = 0; dz = 0;
      xi = longint'($signed(node_mem[i]));
      for (int j = 0; j < n; j++) begin
        if (j == i || dz) continue;
        xj = longint'($signed(node_mem[j]));
        num = longint'(x) - xj;
        den = xi - xj;
        if (den == 0) begin
          dz = 1;
          continue;
        end
        q = (mag * longint'(num < 0 ? -num : num)) / longint'(den < 0 ? -den : den);
        neg = (neg ^ (num < 0)) ^ (den < 0);
        if (q == 0) neg = 0;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) begin
          q = lim;
          sat = 1;
        end
        mag = q;
      end
      b.idx = i[IdxW-1:0];
      b.value = dz ? '0 : (neg ? -mag[DataW-1:0] : mag[DataW-1:0]);
      b.last = (i + 1 == n);
      b.status = dz ? StatusDivZ : (sat ? StatusSat : StatusOk);
      basis_q.push_back(b);
    end
  endtask

  // input acceptance and prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      acc_cnt <= acc_cnt + 1;
      if (mode_i == ModeLoad) node_mem[node_index_i] = node_value_i;
      else predict_basis(point_i);
    end
  end

  // input driver
  always @(negedge clk_i) begin
    node_item_t it;
    if (!in_valid_i || acc_cnt == sent_cnt) begin
      if (in_gap > 0 || pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        it = pending_q.pop_front();
        mode_i <= it.mode;
        node_index_i <= it.idx;
        node_value_i <= it.value;
        point_i <= it.point;
        in_valid_i <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        in_gap <= pick_gap();
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_cnt <= 3000;
      out_stall_i <= 1'b1;
    end else if (out_gap > 0) begin
      out_stall_i <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap <= pick_gap();
    end
  end

  // output checker
  always @(posedge clk_i) begin
    basis_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (basis_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected item idx=%0d value=%h", basis_index_o,
                                    basis_value_o);
      end else begin
        e = basis_q.pop_front();
        if (e.idx !== basis_index_o || e.value !== basis_value_o ||
            e.last !== last_o || e.status !== status_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch exp %0d %h %0b %0d got %0d %h %0b %0d",
                     e.idx, e.value, e.last, e.status,
                     basis_index_o, basis_value_o, last_o, status_o);
        end
      end
    end
  end

  task automatic write_count(input logic [CntW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    node_count_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_reg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_item(input logic m, input logic [IdxW-1:0] i,
                           input logic [DataW-1:0] v, input logic [DataW-1:0] p);
    node_item_t it;
    it.mode = m; it.idx = i; it.value = v; it.point = p;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || basis_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {16'($urandom_range(0, 15)), 16'h0} - 32'h0008_0000;
      2: return $urandom_range(0, 1) ? PosLim : NegLim;
      default: return {13'b0, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535))} ^
                      {32{1'($urandom_range(0, 1))}};
    endcase
  endfunction

  initial begin
    int n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single node, all slots loaded with spread values incl. extremes
    calm = 1;
    write_count(5'd1);
    for (int i = 0; i < 16; i++)
      push_item(ModeLoad, i[IdxW-1:0],
                i == 0 ? NegLim : (i == 15 ? PosLim : (i - 7) * 32'h0100_0000 + 32'h1234),
                $urandom);
    push_item(ModeEval, 4'hF, 32'hFFFF_FFFF, 32'h0);
    push_item(ModeEval, 4'h0, 32'h0, PosLim);
    drain();
    calm = 0;
    write_count(5'd16);
    push_item(ModeEval, IdxW'($urandom), $urandom, 32'h0);
    push_item(ModeEval, IdxW'($urandom), $urandom, NegLim);
    drain();
    write_count(5'd0);
    push_item(ModeEval, IdxW'($urandom), $urandom, NegLim);
    drain();
    write_count(5'd31);
    push_item(ModeEval, IdxW'($urandom), $urandom, 32'h0001_0000);
    drain();
    // coincident nodes, then close nodes with far point to saturate
    write_count(5'd3);
    push_item(ModeLoad, 4'd0, 32'h0001_0000, $urandom);
    push_item(ModeLoad, 4'd1, 32'h0001_0000, $urandom);
    push_item(ModeLoad, 4'd2, 32'h0002_0000, $urandom);
    push_item(ModeEval, IdxW'($urandom), $urandom, 32'h0003_0000);
    push_item(ModeLoad, 4'd0, 32'h0, $urandom);
    push_item(ModeLoad, 4'd1, 32'h1, $urandom);
    push_item(ModeEval, IdxW'($urandom), $urandom, PosLim);
    push_item(ModeEval, IdxW'($urandom), $urandom, NegLim);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 7))
        0: write_count(CntW'($urandom_range(0, 31)));
        1: write_count(5'd16);
        default: write_count(CntW'($urandom_range(1, 5)));
      endcase
      n = (count_reg == 0) ? 1 : (count_reg > 16 ? 16 : int'(count_reg));
      calm = (ph == 4);
      if (ph == 2) hold_gen++;
      for (int k = 0; k < ((n > 8) ? 3 : 12); k++) begin
        if ($urandom_range(0, 9) < 4)
          push_item(ModeLoad, IdxW'($urandom), rand_q16(), $urandom);
        else
          push_item(ModeEval, IdxW'($urandom), $urandom, rand_q16());
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("[lagrange_basis_evaluator] OK");
    end else begin
      $display("[lagrange_basis_evaluator] ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("[lagrange_basis_evaluator] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/lbe_pkg.sv
rtl/lbe_node_cell.sv
rtl/lbe_muldiv.sv
rtl/lagrange_basis_evaluator.sv
sim/tb_top.sv
